// File: hw/rtl/rhc_pkg.sv
// ---------------------------------------------------------------------------
// rhc_pkg
// Types and constants shared by the RGB to HSV converter pipeline.
// ---------------------------------------------------------------------------
package rhc_pkg;

	localparam int CHAN_W    = 8;   // colour channel width
	localparam int QUO_W     = 16;  // quotient bits, one per cell
	localparam int N_CELLS   = QUO_W;
	localparam int HUE_REM_W = 11;  // holds up to 6*255
	localparam int SAT_REM_W = 9;   // holds up to 2*255
	localparam int SAT_N_W   = 17;  // 510*d + max

	// Division state of one item, handed from cell to cell
	typedef struct packed {
		logic [HUE_REM_W-1:0] hue_rem;
		logic [QUO_W-1:0]     hue_lo;   // zeros shifted out, quotient bits shifted in
		logic [HUE_REM_W-1:0] hue_div;
		logic [SAT_REM_W-1:0] sat_rem;
		logic [QUO_W-1:0]     sat_lo;
		logic [SAT_REM_W-1:0] sat_div;
		logic [CHAN_W-1:0]    bright;
	} stage_t;

endpackage

// File: hw/rtl/rhc_front.sv
// ---------------------------------------------------------------------------
// rhc_front
// Max/min search, hue and saturation numerator and divisor set-up for the divider chain.
// ---------------------------------------------------------------------------
module rhc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rhc_pkg::CHAN_W-1:0]    red,
	input  logic [rhc_pkg::CHAN_W-1:0]    green,
	input  logic [rhc_pkg::CHAN_W-1:0]    blue,
	output logic                          out_valid,
	input  logic                          out_ready,
	output rhc_pkg::stage_t               out_stage
);

	logic                              red_max, green_max;
	logic [rhc_pkg::CHAN_W-1:0]        mx, mn, d;
	logic [rhc_pkg::HUE_REM_W-1:0]     d_w, r_w, g_w, b_w, six_d, num, hdiv;
	logic [rhc_pkg::SAT_N_W-1:0]       d_n, sat_n;
	logic [rhc_pkg::SAT_REM_W-1:0]     sdiv;
	rhc_pkg::stage_t                   st;
	rhc_pkg::stage_t                   stage_q;
	logic                              valid_q;
	logic                              load;

	always_comb begin
		red_max   = (red >= green) && (red >= blue);
		green_max = !red_max && (green >= blue);
		if (red_max) begin
			mx = red;
		end else if (green_max) begin
			mx = green;
		end else begin
			mx = blue;
		end
		mn = red;
		if (green < mn) begin
			mn = green;
		end
		if (blue < mn) begin
			mn = blue;
		end
		d = mx - mn;

		d_w   = {{(rhc_pkg::HUE_REM_W-rhc_pkg::CHAN_W){1'b0}}, d};
		r_w   = {{(rhc_pkg::HUE_REM_W-rhc_pkg::CHAN_W){1'b0}}, red};
		g_w   = {{(rhc_pkg::HUE_REM_W-rhc_pkg::CHAN_W){1'b0}}, green};
		b_w   = {{(rhc_pkg::HUE_REM_W-rhc_pkg::CHAN_W){1'b0}}, blue};
		six_d = (d_w << 2) + (d_w << 1);

		// modular arithmetic: the final numerator always lies in [0, 6d)
		if (red_max) begin
			num = (green < blue) ? six_d - (b_w - g_w) : g_w - b_w;
		end else if (green_max) begin
			num = (d_w << 1) + b_w - r_w;
		end else begin
			num = (d_w << 2) + r_w - g_w;
		end

		// grey: numerator 0 over 1 gives a zero quotient
		if (d == '0) begin
			num  = '0;
			hdiv = {{(rhc_pkg::HUE_REM_W-1){1'b0}}, 1'b1};
		end else begin
			hdiv = six_d;
		end

		// saturation = floor((510d + mx) / (2mx)), quotient < 256
		d_n   = {{(rhc_pkg::SAT_N_W-rhc_pkg::CHAN_W){1'b0}}, d};
		sat_n = (d_n << 9) - (d_n << 1)
		      + {{(rhc_pkg::SAT_N_W-rhc_pkg::CHAN_W){1'b0}}, mx};
		sdiv  = (mx == '0) ? {{(rhc_pkg::SAT_REM_W-1){1'b0}}, 1'b1} : {mx, 1'b0};

		st.hue_rem = num;
		st.hue_lo  = '0;
		st.hue_div = hdiv;
		// top bits start as remainder; low bits shifted in, padded by eight zeros
		st.sat_rem = sat_n[rhc_pkg::SAT_N_W-1:rhc_pkg::CHAN_W];
		st.sat_lo  = {sat_n[rhc_pkg::CHAN_W-1:0], {(rhc_pkg::QUO_W-rhc_pkg::CHAN_W){1'b0}}};
		st.sat_div = sdiv;
		st.bright  = mx;
	end

	assign load     = !valid_q || out_ready;
	assign in_ready = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			stage_q <= st;
		end
	end

	assign out_valid = valid_q;
	assign out_stage = stage_q;

endmodule

// File: hw/rtl/rhc_div_cell.sv
// ---------------------------------------------------------------------------
// rhc_div_cell
// One restoring division step for the hue and saturation lanes.
// ---------------------------------------------------------------------------
module rhc_div_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  rhc_pkg::stage_t in_stage,
	output logic            out_valid,
	input  logic            out_ready,
	output rhc_pkg::stage_t out_stage
);

	logic [rhc_pkg::HUE_REM_W:0] hue_trial, hue_sub;
	logic [rhc_pkg::SAT_REM_W:0] sat_trial, sat_sub;
	logic                        hue_ge, sat_ge;
	rhc_pkg::stage_t             nxt;
	rhc_pkg::stage_t             stage_q;
	logic                        valid_q;
	logic                        load;

	always_comb begin
		hue_trial = {in_stage.hue_rem, in_stage.hue_lo[rhc_pkg::QUO_W-1]};
		hue_ge    = hue_trial >= {1'b0, in_stage.hue_div};
		hue_sub   = hue_trial - {1'b0, in_stage.hue_div};
		sat_trial = {in_stage.sat_rem, in_stage.sat_lo[rhc_pkg::QUO_W-1]};
		sat_ge    = sat_trial >= {1'b0, in_stage.sat_div};
		sat_sub   = sat_trial - {1'b0, in_stage.sat_div};

		nxt         = in_stage;
		nxt.hue_rem = hue_ge ? hue_sub[rhc_pkg::HUE_REM_W-1:0]
		                     : hue_trial[rhc_pkg::HUE_REM_W-1:0];
		nxt.hue_lo  = {in_stage.hue_lo[rhc_pkg::QUO_W-2:0], hue_ge};
		nxt.sat_rem = sat_ge ? sat_sub[rhc_pkg::SAT_REM_W-1:0]
		                     : sat_trial[rhc_pkg::SAT_REM_W-1:0];
		nxt.sat_lo  = {in_stage.sat_lo[rhc_pkg::QUO_W-2:0], sat_ge};
	end

	assign load     = !valid_q || out_ready;
	assign in_ready = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			stage_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_stage = stage_q;

endmodule

// File: hw/rtl/rgb_to_hsv_converter.sv
// Structure: one registered set-up stage, then one registered division
// cell per quotient bit, between an accepted item and m_tvalid.
// Throughput: one item per cycle when m_tready does not stall it; each of
// the 16 cells retires one hue and one saturation quotient bit, passing it on.
// Reset: arst_n clears every stage valid bit; data registers are not reset.
// ---------------------------------------------------------------------------
// rgb_to_hsv_converter
// Streaming RGB to HSV conversion built as a chain of restoring divider cells.
// ---------------------------------------------------------------------------
module rgb_to_hsv_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // hue[15:0], saturation[23:16], brightness[31:24]
);

	rhc_pkg::stage_t chain [0:rhc_pkg::N_CELLS];
	logic            vld   [0:rhc_pkg::N_CELLS];
	logic            rdy   [0:rhc_pkg::N_CELLS];
	rhc_pkg::stage_t last;

	rhc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.red       (s_tdata[7:0]),
		.green     (s_tdata[15:8]),
		.blue      (s_tdata[23:16]),
		.out_valid (vld[0]),
		.out_ready (rdy[0]),
		.out_stage (chain[0])
	);

	for (genvar i = 0; i < rhc_pkg::N_CELLS; i++) begin : g_cell
		rhc_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld[i]),
			.in_ready  (rdy[i]),
			.in_stage  (chain[i]),
			.out_valid (vld[i+1]),
			.out_ready (rdy[i+1]),
			.out_stage (chain[i+1])
		);
	end

	assign rdy[rhc_pkg::N_CELLS] = m_tready;
	assign last                  = chain[rhc_pkg::N_CELLS];
	assign m_tvalid              = vld[rhc_pkg::N_CELLS];
	// saturation quotient carries eight extra fraction bits; keep the integer part
	assign m_tdata = {last.bright,
	                  last.sat_lo[rhc_pkg::QUO_W-1:rhc_pkg::QUO_W-rhc_pkg::CHAN_W],
	                  last.hue_lo};

	// an empty output stage lets the whole chain move
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output stage empty");

	a_black_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[31:24] == 8'd0) |-> (m_tdata[23:0] == 24'd0))
		else $error("black pixel with non-zero hue or saturation");

	a_grey_hue: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[23:16] == 8'd0) |-> (m_tdata[15:0] == 16'd0))
		else $error("zero saturation with non-zero hue");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[31:24] != 8'd0) && (m_tdata[15:0] != 16'd0)
		|-> (m_tdata[23:16] != 8'd0))
		else $error("coloured pixel with zero saturation");

endmodule
